/* src/lrupr_pkg.sv */
// ---------------------------------------------------------------------------
// LRU page replacement list - shared types
// Request and status codes, controller states, list entry layout and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package lrupr_pkg;

   localparam int PAGE_W   = 16;
   localparam int ADDR_W   = 27;
   localparam int OCC_W    = 5;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_TOUCH  = 2'd1,
      REQ_EVICT  = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_MISS  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PLACE
   } state_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [ADDR_W-1:0] addr;
   } entry_type;

   typedef struct packed {
      logic       load_key;
      logic       insert;
      logic       scan_start;
      logic       scan_run;
      logic       match_all;
      logic       grab;
      logic       shift_run;
      logic       place;
      logic       dec_count;
      logic       respond;
      logic       victim_sel;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic hit;
      logic last;
   } dp_stat_type;

endpackage

/* src/lrupr_dp.sv */
// ---------------------------------------------------------------------------
// LRU page replacement list - datapath
// Entry memory (position 0 least recent), occupancy count, scan/shift
// pointers with registered read data, and the response registers.
// ---------------------------------------------------------------------------
module lrupr_dp
   import lrupr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [PAGE_W-1:0]   req_page_id,
   input  logic [ADDR_W-1:0]   req_page_addr,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_victim_page,
   output logic [ADDR_W-1:0]   rsp_victim_addr,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   entry_type             mem_ff [CAPACITY];
   entry_type             rdata_ff;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      ridx_ff, ridx_in;
   logic                  rvalid_ff, rvalid_in;
   logic [ADDR_W-1:0]     key_ff, key_in;
   entry_type             hold_ff, hold_in;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   entry_type             rsp_victim_ff, rsp_victim_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  we;
   logic [IDX_W-1:0]      wa;
   entry_type             wd;
   logic                  rd_ok;

   assign rd_ok = idx_ff < count_ff;

   assign stat.full  = count_ff == CNT_W'(CAPACITY);
   assign stat.empty = count_ff == '0;
   assign stat.hit   = rvalid_ff && (cmd.match_all || rdata_ff.addr == key_ff);
   assign stat.last  = rvalid_ff && ((CNT_W'(ridx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      ridx_in       = ridx_ff;
      rvalid_in     = 1'b0;
      key_in        = key_ff;
      hold_in       = hold_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IDX_W-1:0];
      we            = 1'b0;
      wa            = ridx_ff - IDX_W'(1);
      wd            = rdata_ff;
      rsp_status_in = rsp_status_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (cmd.load_key) begin
         key_in = req_page_addr;
      end
      if (cmd.scan_start) begin
         idx_in = '0;
      end
      if (cmd.scan_run || cmd.shift_run) begin
         rd_en     = rd_ok;
         rvalid_in = rd_ok;
         ridx_in   = idx_ff[IDX_W-1:0];
         idx_in    = idx_ff + CNT_W'(1);
      end
      if (cmd.grab) begin
         hold_in   = rdata_ff;
         idx_in    = CNT_W'(ridx_ff) + CNT_W'(1);
         rvalid_in = 1'b0;
      end
      // close the gap: entry read at ridx moves down one position
      if (cmd.shift_run && rvalid_ff) begin
         we = 1'b1;
         wa = ridx_ff - IDX_W'(1);
         wd = rdata_ff;
      end
      if (cmd.insert) begin
         we       = 1'b1;
         wa       = count_ff[IDX_W-1:0];
         wd.page  = req_page_id;
         wd.addr  = req_page_addr;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.place) begin
         we = 1'b1;
         wa = IDX_W'(count_ff - CNT_W'(1));
         wd = hold_ff;
         if (cmd.dec_count) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      if (cmd.respond) begin
         rsp_status_in = cmd.status;
         rsp_victim_in = cmd.victim_sel ? hold_ff : '0;
         rsp_occ_in    = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      ridx_ff       <= ridx_in;
      key_ff        <= key_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_victim_page = rsp_victim_ff.page;
   assign rsp_victim_addr = rsp_victim_ff.addr;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule

/* src/lrupr_ctrl.sv */
// ---------------------------------------------------------------------------
// LRU page replacement list - controller
// Decodes a request and sequences scan, shift and place steps of the
// datapath; issues the response command.
// ---------------------------------------------------------------------------
module lrupr_ctrl
   import lrupr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [REQ_W-1:0] req_type,
   input  dp_stat_type      stat,
   output dp_cmd_type       cmd,
   output logic             busy
);

   state_type state_ff, state_in;
   logic      evict_ff, evict_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      evict_ff <= evict_in;
   end

   always_comb begin
      state_in = state_ff;
      evict_in = evict_ff;
      cmd      = '0;
      cmd.status = ST_DONE;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_INSERT: begin
                     cmd.respond = 1'b1;
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                     end
                  end
                  REQ_TOUCH: begin
                     if (stat.empty) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_MISS;
                     end else begin
                        cmd.load_key   = 1'b1;
                        cmd.scan_start = 1'b1;
                        evict_in       = 1'b0;
                        state_in       = S_SCAN;
                     end
                  end
                  REQ_EVICT: begin
                     if (stat.empty) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        evict_in       = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  default: begin
                     cmd.respond = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.match_all = evict_ff;
            if (stat.hit) begin
               cmd.grab = 1'b1;
               state_in = stat.last ? S_PLACE : S_SHIFT;
            end else if (stat.last) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_MISS;
               state_in    = S_IDLE;
            end
         end

         S_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (stat.last) begin
               state_in = S_PLACE;
            end
         end

         S_PLACE: begin
            cmd.place      = 1'b1;
            cmd.dec_count  = evict_ff;
            cmd.respond    = 1'b1;
            cmd.victim_sel = evict_ff;
            state_in       = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = state_ff != S_IDLE;

endmodule

/* src/lru_page_replacement_list.sv */
// ---------------------------------------------------------------------------
// LRU page replacement list - top level
// Recency-ordered list of resident pages with insert, touch and evict.
//
//   channel   handshake           payload
//   request   start & !busy       req_type, req_page_id, req_page_addr
//   response  rsp_valid (1 cycle) rsp_status, rsp_victim_page,
//                                 rsp_victim_addr, rsp_occupancy
//
// Insert, unused codes and requests on an empty list are answered from the
// idle state; busy stays low. Touch and evict walk the entry memory through
// its single read port: a scan up to the matching position, a shift of the
// younger entries down one place, then a write at the young end; busy stays
// high for the whole walk.
// The response appears the cycle after the request completes.
// Reset empties the list; the receiver cannot stall the response.
// ---------------------------------------------------------------------------
module lru_page_replacement_list
   import lrupr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [PAGE_W-1:0]   req_page_id,
   input  logic [ADDR_W-1:0]   req_page_addr,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_victim_page,
   output logic [ADDR_W-1:0]   rsp_victim_addr,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lrupr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   lrupr_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_page_id     (req_page_id),
      .req_page_addr   (req_page_addr),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_victim_page (rsp_victim_page),
      .rsp_victim_addr (rsp_victim_addr),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule

/* sim/lru_page_replacement_list_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LRU page replacement list - testbench
// Drives insert, touch, evict and unused requests with random gaps and
// mirrors the recency list in a scoreboard. Each response is checked field
// by field against the oldest predicted outcome.
// ---------------------------------------------------------------------------

class page_list_scoreboard;

   typedef struct {
      lrupr_pkg::status_type                 status;
      logic [lrupr_pkg::PAGE_W-1:0]          victim_page;
      logic [lrupr_pkg::ADDR_W-1:0]          victim_addr;
      logic [lrupr_pkg::OCC_W-1:0]           occupancy;
   } outcome_type;

   lrupr_pkg::entry_type resident[$];
   outcome_type          outcomes[$];
   int                   depth;
   int                   errors;

   function new(int list_depth);
      depth  = list_depth;
      errors = 0;
   endfunction

   function int count();
      return resident.size();
   endfunction

   function int pending();
      return outcomes.size();
   endfunction

   function logic [lrupr_pkg::ADDR_W-1:0] addr_at(int idx);
      return resident[idx].addr;
   endfunction

   task report(string what);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, what);
   endtask

   // Accepted request: update the mirrored list and queue the outcome.
   function void note_request(logic [lrupr_pkg::REQ_W-1:0] kind,
                              logic [lrupr_pkg::PAGE_W-1:0] page,
                              logic [lrupr_pkg::ADDR_W-1:0] addr);
      outcome_type          o;
      lrupr_pkg::entry_type e;
      int                   hit;
      o.status      = lrupr_pkg::ST_DONE;
      o.victim_page = '0;
      o.victim_addr = '0;
      hit           = -1;
      case (kind)
         lrupr_pkg::REQ_INSERT: begin
            if (resident.size() >= depth) begin
               o.status = lrupr_pkg::ST_FULL;
            end else begin
               e.page = page;
               e.addr = addr;
               resident.push_back(e);
            end
         end
         lrupr_pkg::REQ_TOUCH: begin
            for (int i = 0; i < resident.size(); i++) begin
               if (resident[i].addr == addr) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) begin
               o.status = lrupr_pkg::ST_MISS;
            end else begin
               e = resident[hit];
               resident.delete(hit);
               resident.push_back(e);
            end
         end
         lrupr_pkg::REQ_EVICT: begin
            if (resident.size() == 0) begin
               o.status = lrupr_pkg::ST_EMPTY;
            end else begin
               e = resident.pop_front();
               o.victim_page = e.page;
               o.victim_addr = e.addr;
            end
         end
         default: ;
      endcase
      o.occupancy = lrupr_pkg::OCC_W'(resident.size());
      outcomes.push_back(o);
   endfunction

   task check_response(logic [lrupr_pkg::STATUS_W-1:0] status,
                       logic [lrupr_pkg::PAGE_W-1:0]   victim_page,
                       logic [lrupr_pkg::ADDR_W-1:0]   victim_addr,
                       logic [lrupr_pkg::OCC_W-1:0]    occupancy);
      outcome_type o;
      if (outcomes.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      o = outcomes.pop_front();
      if (status !== o.status)
         report($sformatf("status %0h, want %0h", status, o.status));
      if (victim_page !== o.victim_page)
         report($sformatf("victim page %0h, want %0h", victim_page, o.victim_page));
      if (victim_addr !== o.victim_addr)
         report($sformatf("victim addr %0h, want %0h", victim_addr, o.victim_addr));
      if (occupancy !== o.occupancy)
         report($sformatf("occupancy %0d, want %0d", occupancy, o.occupancy));
   endtask

endclass

module lru_page_replacement_list_tb
   import lrupr_pkg::*;
;

   localparam int               LIST_DEPTH     = 16;
   localparam int               WATCHDOG_LIMIT = 2000;
   localparam int               DRAIN_CYCLES   = 2 * LIST_DEPTH + 8;
   localparam logic [REQ_W-1:0] REQ_UNUSED     = 2'd3;
   localparam logic [PAGE_W-1:0] PAGE_MAX      = '1;
   localparam logic [ADDR_W-1:0] ADDR_MAX      = '1;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic [REQ_W-1:0]    req_type      = '0;
   logic [PAGE_W-1:0]   req_page_id   = '0;
   logic [ADDR_W-1:0]   req_page_addr = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [PAGE_W-1:0]   rsp_victim_page;
   logic [ADDR_W-1:0]   rsp_victim_addr;
   logic [OCC_W-1:0]    rsp_occupancy;

   page_list_scoreboard sb;
   logic [ADDR_W-1:0]   addr_pool [8];
   int                  stall_cycles = 0;
   bit                  idling       = 1'b1;

   lru_page_replacement_list #(.CAPACITY(LIST_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_page_id     (req_page_id),
      .req_page_addr   (req_page_addr),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_victim_page (rsp_victim_page),
      .rsp_victim_addr (rsp_victim_addr),
      .rsp_occupancy   (rsp_occupancy)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid === 1'b1)
            sb.check_response(rsp_status, rsp_victim_page, rsp_victim_addr, rsp_occupancy);
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic [PAGE_W-1:0] page,
                               input logic [ADDR_W-1:0] addr);
      @(negedge clock);
      start         <= 1'b1;
      req_type      <= kind;
      req_page_id   <= page;
      req_page_addr <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(kind, page, addr);
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic maybe_rest();
      if (idling && $urandom_range(0, 3) == 0) rest($urandom_range(1, 14));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_request(input int insert_pct, input int evict_pct);
      int                roll;
      logic [REQ_W-1:0]  kind;
      logic [PAGE_W-1:0] page;
      logic [ADDR_W-1:0] addr;
      roll = $urandom_range(0, 99);
      page = PAGE_W'($urandom);
      addr = $urandom_range(0, 1) ? addr_pool[$urandom_range(0, 7)] : ADDR_W'($urandom);
      if (roll < insert_pct) kind = REQ_INSERT;
      else if (roll < insert_pct + evict_pct) kind = REQ_EVICT;
      else if (roll < 96) kind = REQ_TOUCH;
      else kind = REQ_UNUSED;
      // most touches aim at a resident page so they hit
      if (kind == REQ_TOUCH && sb.count() > 0 && $urandom_range(0, 3) != 0)
         addr = sb.addr_at($urandom_range(0, sb.count() - 1));
      send_request(kind, page, addr);
      maybe_rest();
   endtask

   initial begin
      sb = new(LIST_DEPTH);
      addr_pool[0] = '0;
      addr_pool[1] = ADDR_MAX;
      for (int i = 2; i < 8; i++) addr_pool[i] = ADDR_W'($urandom);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list, unused code, extremes, duplicates, full list
      send_request(REQ_EVICT, '0, '0);
      send_request(REQ_TOUCH, '0, '0);
      send_request(REQ_UNUSED, PAGE_MAX, ADDR_MAX);
      send_request(REQ_INSERT, '0, '0);
      send_request(REQ_INSERT, PAGE_MAX, ADDR_MAX);
      send_request(REQ_INSERT, 16'h1234, '0);
      send_request(REQ_TOUCH, '0, '0);
      send_request(REQ_TOUCH, '0, ADDR_MAX);
      send_request(REQ_TOUCH, '0, 27'h5555);
      send_request(REQ_EVICT, '0, '0);
      while (sb.count() < LIST_DEPTH)
         send_request(REQ_INSERT, PAGE_W'($urandom), ADDR_W'(sb.count() + 1));
      send_request(REQ_INSERT, PAGE_MAX, ADDR_MAX);
      send_request(REQ_TOUCH, '0, ADDR_W'(LIST_DEPTH / 2));
      send_request(REQ_EVICT, '0, '0);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         idling = (phase < 5);
         for (int n = 0; n < 100; n++) begin
            if (phase % 2 == 0) random_request(55, 15);
            else random_request(25, 40);
         end
         if (phase < 5) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
